>>> rtl/core/dpq_pkg.sv
`timescale 1ns / 1ps

package dpq_pkg;

    localparam int DEPTH_DEFAULT = 256;
    localparam int COORD_W       = 8;
    localparam int FUNC_W        = 2;
    localparam int STATUS_W      = 3;
    localparam int SLOT_W        = 8;

    // request operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_INSERT = 2'd0,
        FN_REMOVE = 2'd1,
        FN_FIND   = 2'd2
    } func_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_FOUND = 3'd4
    } status_t;

    // sequencer states
    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_FINISH
    } fsm_t;

    // one stored coordinate pair
    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } entry_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic valid;
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

>>> rtl/core/dpq_cell.sv
`timescale 1ns / 1ps

module dpq_cell (
    input  logic                clk,
    input  dpq_pkg::cell_ctrl_t ctrl,
    input  dpq_pkg::entry_t     key,
    input  dpq_pkg::entry_t     shift_in,
    output dpq_pkg::entry_t     data,
    output logic                hit
);

    dpq_pkg::entry_t data_reg;
    dpq_pkg::entry_t data_next;

    // shift from the right neighbor wins over a load
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = shift_in;
        end
        else if (ctrl.load)
        begin
            data_next = key;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = ctrl.valid && (data_reg == key);

endmodule

>>> rtl/core/dpq_match_tree.sv
`timescale 1ns / 1ps

module dpq_match_tree #(
    parameter int DEPTH = dpq_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic [DEPTH-1:0]         hits,
    output logic                     root_hit,
    output logic [$clog2(DEPTH)-1:0] root_idx
);

    localparam int IW = $clog2(DEPTH);
    localparam int P  = 1 << IW;

    // heap layout: node n has children 2n and 2n+1, leaves are P .. 2P-1
    logic          hit_reg  [1:P-1];
    logic [IW-1:0] idx_reg  [1:P-1];
    wire           hit_next [1:P-1];
    wire  [IW-1:0] idx_next [1:P-1];

    for (genvar n = 1; n < P; n++)
    begin : g_node
        wire          l_hit;
        wire          r_hit;
        wire [IW-1:0] l_idx;
        wire [IW-1:0] r_idx;

        if (2 * n >= P)
        begin : g_leaf
            localparam int LI = 2 * n - P;
            localparam int RI = LI + 1;
            if (LI < DEPTH)
            begin : g_l
                assign l_hit = hits[LI];
            end
            else
            begin : g_lpad
                assign l_hit = 1'b0;
            end
            if (RI < DEPTH)
            begin : g_r
                assign r_hit = hits[RI];
            end
            else
            begin : g_rpad
                assign r_hit = 1'b0;
            end
            assign l_idx = l_hit ? IW'(LI) : '0;
            assign r_idx = r_hit ? IW'(RI) : '0;
        end
        else
        begin : g_inner
            assign l_hit = hit_reg[2*n];
            assign r_hit = hit_reg[2*n+1];
            assign l_idx = idx_reg[2*n];
            assign r_idx = idx_reg[2*n+1];
        end

        // at most one hit in the row, so an or-merge of indexes is exact
        assign hit_next[n] = l_hit | r_hit;
        assign idx_next[n] = l_idx | r_idx;
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
        idx_reg <= idx_next;
    end

    assign root_hit = hit_reg[1];
    assign root_idx = idx_reg[1];

endmodule

>>> rtl/core/dedup_position_queue.sv
`timescale 1ns / 1ps

// channel | direction | handshake              | payload
// --------+-----------+------------------------+---------------------------------
// request | in        | in_valid / in_ready    | func, row, col
// result  | out       | out_valid / out_ready  | status, slot, out_row, out_col
//
// insert and find wait in the search state for the registered match tree to
// reach its root; remove and unknown codes go straight to the finish state
// rst_n clears the sequencer, the fill count and the result valid flag; the
// entry cells are not cleared, cells at or above the count never match
// a new request is taken while a finished result still waits in the output
// register; the result commits once that register is free

module dedup_position_queue #(
    parameter int DEPTH = dpq_pkg::DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [dpq_pkg::FUNC_W-1:0]      func,
    input  logic [dpq_pkg::COORD_W-1:0]     row,
    input  logic [dpq_pkg::COORD_W-1:0]     col,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [dpq_pkg::STATUS_W-1:0]    status,
    output logic [dpq_pkg::SLOT_W-1:0]      slot,
    output logic [dpq_pkg::COORD_W-1:0]     out_row,
    output logic [dpq_pkg::COORD_W-1:0]     out_col
);

    localparam int IW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int SCW = $clog2(IW + 1);

    // sequencer
    dpq_pkg::fsm_t state_reg;
    dpq_pkg::fsm_t state_next;
    logic [SCW-1:0] search_cnt_reg;
    logic [SCW-1:0] search_cnt_next;

    // latched request
    logic [dpq_pkg::FUNC_W-1:0] func_reg;
    dpq_pkg::entry_t            key_reg;

    // fill count
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // result register
    logic                         out_valid_reg;
    logic [dpq_pkg::STATUS_W-1:0] status_reg;
    logic [dpq_pkg::SLOT_W-1:0]   slot_reg;
    logic [dpq_pkg::COORD_W-1:0]  out_row_reg;
    logic [dpq_pkg::COORD_W-1:0]  out_col_reg;

    // result being formed in the finish state
    logic [dpq_pkg::STATUS_W-1:0] status_next;
    logic [dpq_pkg::SLOT_W-1:0]   slot_next;
    logic [dpq_pkg::COORD_W-1:0]  out_row_next;
    logic [dpq_pkg::COORD_W-1:0]  out_col_next;

    logic accept;
    logic commit;
    logic do_load;
    logic do_shift;
    logic is_full;
    logic is_empty;

    // cell row and match tree
    wire dpq_pkg::entry_t cell_data [DEPTH];
    wire [DEPTH-1:0]      hits;
    logic                 root_hit;
    logic [IW-1:0]        root_idx;

    assign accept   = in_valid && in_ready;
    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_empty = (count_reg == '0);

    // ------------------------------------------------------------------
    // row of cells: each compares against the key, loads at the tail,
    // and takes its right neighbor's pair when the front is removed
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        dpq_pkg::entry_t     right;
        dpq_pkg::cell_ctrl_t ctrl;

        if (i == DEPTH - 1)
        begin : g_last
            assign right = cell_data[i];
        end
        else
        begin : g_mid
            assign right = cell_data[i+1];
        end

        assign ctrl.valid = (CW'(i) < count_reg);
        assign ctrl.load  = do_load && (count_reg == CW'(i));
        assign ctrl.shift = do_shift;

        dpq_cell u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .key      (key_reg),
            .shift_in (right),
            .data     (cell_data[i]),
            .hit      (hits[i])
        );
    end

    // registered or-tree turns the one-hot hit row into an index
    dpq_match_tree #(
        .DEPTH (DEPTH)
    ) u_match_tree (
        .clk      (clk),
        .hits     (hits),
        .root_hit (root_hit),
        .root_idx (root_idx)
    );

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dpq_pkg::FSM_IDLE:
            begin
                if (in_valid)
                begin
                    // searches wait for the tree, the rest finish at once
                    if (func == dpq_pkg::FN_INSERT || func == dpq_pkg::FN_FIND)
                    begin
                        state_next = dpq_pkg::FSM_SEARCH;
                    end
                    else
                    begin
                        state_next = dpq_pkg::FSM_FINISH;
                    end
                end
            end
            dpq_pkg::FSM_SEARCH:
            begin
                if (search_cnt_reg == '0)
                begin
                    state_next = dpq_pkg::FSM_FINISH;
                end
            end
            dpq_pkg::FSM_FINISH:
            begin
                if (commit)
                begin
                    state_next = dpq_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = dpq_pkg::FSM_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer outputs and result forming
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ready        = 1'b0;
        commit          = 1'b0;
        do_load         = 1'b0;
        do_shift        = 1'b0;
        search_cnt_next = search_cnt_reg;
        status_next     = dpq_pkg::ST_DONE;
        slot_next       = '0;
        out_row_next    = '0;
        out_col_next    = '0;
        count_next      = count_reg;

        case (state_reg)
            dpq_pkg::FSM_IDLE:
            begin
                in_ready        = 1'b1;
                // counter spans the register levels between the latched key and the tree root
                search_cnt_next = SCW'(IW - 1);
            end
            dpq_pkg::FSM_SEARCH:
            begin
                if (search_cnt_reg != '0)
                begin
                    search_cnt_next = search_cnt_reg - 1'b1;
                end
            end
            dpq_pkg::FSM_FINISH:
            begin
                commit = !out_valid_reg || out_ready;
                case (func_reg)
                    dpq_pkg::FN_INSERT:
                    begin
                        if (root_hit)
                        begin
                            status_next = dpq_pkg::ST_PRESENT;
                            slot_next   = dpq_pkg::SLOT_W'(root_idx);
                        end
                        else if (is_full)
                        begin
                            status_next = dpq_pkg::ST_FULL;
                        end
                        else
                        begin
                            // new pair goes at the tail
                            slot_next = dpq_pkg::SLOT_W'(count_reg);
                            do_load   = commit;
                        end
                    end
                    dpq_pkg::FN_REMOVE:
                    begin
                        if (is_empty)
                        begin
                            status_next = dpq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            out_row_next = cell_data[0].row;
                            out_col_next = cell_data[0].col;
                            do_shift     = commit;
                        end
                    end
                    dpq_pkg::FN_FIND:
                    begin
                        if (root_hit)
                        begin
                            slot_next = dpq_pkg::SLOT_W'(root_idx);
                        end
                        else
                        begin
                            status_next = dpq_pkg::ST_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        // unknown code: all-zero result, no change
                        status_next = dpq_pkg::ST_DONE;
                    end
                endcase

                if (do_load)
                begin
                    count_next = count_reg + 1'b1;
                end
                else if (do_shift)
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= dpq_pkg::FSM_IDLE;
            search_cnt_reg <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            search_cnt_reg <= search_cnt_next;
            count_reg      <= count_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // request and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg    <= func;
            key_reg.row <= row;
            key_reg.col <= col;
        end
        if (commit)
        begin
            status_reg  <= status_next;
            slot_reg    <= slot_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign slot      = slot_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // fill count never passes the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    // stored pairs are unique, so at most one cell can match
    a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hits))
        else $error("more than one cell matched the key");

    // an accepted insert grows the count by exactly one
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        do_load |=> count_reg == CW'($past(count_reg) + 1'b1))
        else $error("insert did not advance the count");

    // a pending full status means the store really is full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == dpq_pkg::ST_FULL |-> is_full)
        else $error("full status with free cells");

    // every accepted transaction leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != dpq_pkg::FSM_IDLE)
        else $error("sequencer stayed idle after a transaction");

endmodule
